// ===== hw/rtl/value_container_lowest_index_table_defines.svh =====
// Assertion macros shared by the value container checker
`ifndef VALUE_CONTAINER_LOWEST_INDEX_TABLE_DEFINES_SVH
`define VALUE_CONTAINER_LOWEST_INDEX_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define VCLIT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define VCLIT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vclit_pkg.sv =====
// Shared types and constants of the value container lowest index table
package vclit_pkg;

    localparam int SLOT_INDEX_W = 10;
    localparam int VALUE_W      = 32;

    localparam logic ACT_CHANGE = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } vclit_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } vclit_mem_cmd_t;

endpackage

// ===== hw/rtl/vclit_in_if.sv =====
// Command channel: action, slot index and value with valid/ready
interface vclit_in_if
    import vclit_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [SLOT_INDEX_W-1:0]        slot_index;
    logic signed [VALUE_W-1:0]      value;

    modport source (output valid, output action, output slot_index, output value,
                    input ready);
    modport sink   (input valid, input action, input slot_index, input value,
                    output ready);
endinterface

// ===== hw/rtl/vclit_out_if.sv =====
// Response channel: found flag and lowest matching slot with valid/ready
interface vclit_out_if
    import vclit_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [SLOT_INDEX_W-1:0] lowest_slot;

    modport source (output valid, output found, output lowest_slot, input ready);
    modport sink   (input valid, input found, input lowest_slot, output ready);
endinterface

// ===== hw/rtl/vclit_ram.sv =====
// Slot memory: one write port, one read port, registered read data
module vclit_ram
    import vclit_pkg::*;
#(
    parameter int NUM_SLOTS = 1024,
    parameter int AW        = 10
) (
    input  logic           clk,
    input  vclit_mem_cmd_t cmd,
    input  logic [AW-1:0]  wr_addr,
    input  vclit_entry_t   wr_data,
    input  logic [AW-1:0]  rd_addr,
    output vclit_entry_t   rd_data
);

    vclit_entry_t mem_reg [NUM_SLOTS];
    vclit_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/vclit_ctrl.sv =====
// Sequencer: clear pass, slot writes, ordered scan and response register
module vclit_ctrl
    import vclit_pkg::*;
#(
    parameter int NUM_SLOTS = 1024,
    parameter int AW        = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    vclit_in_if.sink       cmd,
    vclit_out_if.source    rsp,
    output vclit_mem_cmd_t mem_cmd,
    output logic [AW-1:0]  wr_addr,
    output vclit_entry_t   wr_data,
    output logic [AW-1:0]  rd_addr,
    input  vclit_entry_t   rd_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

    state_t                    state_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [AW-1:0]             scan_addr_reg;
    logic                      pend_reg;
    logic [AW-1:0]             pend_addr_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      res_found_reg;
    logic [AW-1:0]             res_slot_reg;
    logic                      rsp_valid_reg;
    logic                      rsp_found_reg;
    logic [SLOT_INDEX_W-1:0]   rsp_slot_reg;

    logic accept;
    logic in_range;
    logic match;
    logic last_check;
    logic rsp_free;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign in_range   = (32'(cmd.slot_index) < 32'(NUM_SLOTS));
    assign match      = pend_reg && rd_data.valid && (rd_data.value == key_reg);
    assign last_check = (pend_addr_reg == LAST_ADDR);
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        mem_cmd.wr_en = (state_reg == ST_CLEAR)
                     || (accept && (cmd.action == ACT_CHANGE) && in_range);
        mem_cmd.rd_en = (state_reg == ST_SCAN);
        if (state_reg == ST_CLEAR)
        begin
            wr_addr       = clr_addr_reg;
            wr_data.valid = 1'b0;
            wr_data.value = '0;
        end
        else
        begin
            wr_addr       = AW'(cmd.slot_index);
            wr_data.valid = 1'b1;
            wr_data.value = cmd.value;
        end
        rd_addr = scan_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (cmd.action == ACT_FIND))
                    begin
                        key_reg       <= cmd.value;
                        scan_addr_reg <= '0;
                        pend_reg      <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // advance the read pointer; check the beat read last cycle
                    pend_reg      <= 1'b1;
                    pend_addr_reg <= scan_addr_reg;
                    if (scan_addr_reg != LAST_ADDR)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (match)
                    begin
                        res_found_reg <= 1'b1;
                        res_slot_reg  <= pend_addr_reg;
                        pend_reg      <= 1'b0;
                        state_reg     <= ST_DONE;
                    end
                    else if (pend_reg && last_check)
                    begin
                        res_found_reg <= 1'b0;
                        res_slot_reg  <= '0;
                        pend_reg      <= 1'b0;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold the result until the response register frees up
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_found_reg <= res_found_reg;
                        rsp_slot_reg  <= SLOT_INDEX_W'(res_slot_reg);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        rsp_valid_reg <= rsp_valid_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.lowest_slot = rsp_slot_reg;

endmodule

// ===== hw/rtl/value_container_lowest_index_table.sv =====
// Top level of the value container lowest index table
// After reset the block sweeps the slot memory once to clear every valid mark,
// with cmd.ready low throughout. A change beat is written in the cycle it is
// accepted and gives no response. A find beat scans the single slot memory from
// slot 0 upward, one read per cycle with registered read data, and stops at the
// first valid slot that holds the value, or after the last slot on a miss; the
// result then waits in the done state until the response register is free. One
// find is in flight at a time; new beats are taken while an earlier response
// still waits on rsp. Slots at or above NUM_SLOTS are ignored on change;
// lowest_slot carries the low 10 bits of the index.
module value_container_lowest_index_table
    import vclit_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    vclit_in_if.sink    cmd,
    vclit_out_if.source rsp
);

    localparam int AW = $clog2(NUM_SLOTS);

    vclit_mem_cmd_t mem_cmd;
    logic [AW-1:0]  wr_addr;
    vclit_entry_t   wr_data;
    logic [AW-1:0]  rd_addr;
    vclit_entry_t   rd_data;

    vclit_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vclit_ram #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_ram (
        .clk     (clk),
        .cmd     (mem_cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hw/rtl/vclit_checker.sv =====
// Port-level checks for the value container table, bound to the top level
`include "value_container_lowest_index_table_defines.svh"

module vclit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_found,
    input logic [9:0] rsp_lowest_slot
);

    `VCLIT_ASSERT_NOW(a_miss_slot_zero, clk, rst_n, rsp_valid && !rsp_found, rsp_lowest_slot == 10'd0, "miss response with nonzero slot")

    `VCLIT_ASSERT_NEXT(a_no_instant_rsp, clk, rst_n, cmd_valid && cmd_ready, !$rose(rsp_valid), "response rose right after a command beat")

    `VCLIT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_lowest_slot), "stalled response changed")

endmodule

bind value_container_lowest_index_table vclit_checker u_vclit_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_lowest_slot (rsp.lowest_slot)
);

// ===== sim/lowest_slot_checker.sv =====
// Checker that predicts and compares the lowest-slot answers of the value table
module lowest_slot_checker
    import vclit_pkg::*;
#(
    parameter int NUM_SLOTS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    vclit_in_if  cmd,
    vclit_out_if rsp,
    output int   mismatches,
    output int   answers_pending,
    output int   finds_matched
);

    typedef struct packed {
        logic                    found;
        logic [SLOT_INDEX_W-1:0] lowest_slot;
    } slot_answer_t;

    logic [VALUE_W-1:0] table_value [NUM_SLOTS];
    logic               table_used  [NUM_SLOTS];
    slot_answer_t       answer_queue [$];
    int                 bad_count;
    int                 pending_count;
    int                 matched_count;

    assign mismatches      = bad_count;
    assign answers_pending = pending_count;
    assign finds_matched   = matched_count;

    function automatic slot_answer_t lookup_lowest(input logic [VALUE_W-1:0] key);
        slot_answer_t ans;
        ans = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (table_used[s] && table_value[s] == key)
            begin
                ans.found       = 1'b1;
                ans.lowest_slot = SLOT_INDEX_W'(s);
                break;
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        slot_answer_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                table_value[s] = '0;
                table_used[s]  = 1'b0;
            end
            answer_queue.delete();
            bad_count     = 0;
            pending_count = 0;
            matched_count = 0;
        end
        else
        begin
            // check the response beat before taking a new command beat
            if (rsp.valid && rsp.ready)
            begin
                if (answer_queue.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("mismatch: response found=%0b slot=%0d with no find pending",
                                 rsp.found, rsp.lowest_slot);
                    bad_count++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (rsp.found !== want.found || rsp.lowest_slot !== want.lowest_slot)
                    begin
                        if (bad_count < 10)
                            $display("mismatch: expected found=%0b slot=%0d, got found=%0b slot=%0d",
                                     want.found, want.lowest_slot, rsp.found, rsp.lowest_slot);
                        bad_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.action == ACT_CHANGE)
                begin
                    if (int'(cmd.slot_index) < NUM_SLOTS)
                    begin
                        table_value[cmd.slot_index] = cmd.value;
                        table_used[cmd.slot_index]  = 1'b1;
                    end
                end
                else
                begin
                    want = lookup_lowest(cmd.value);
                    if (want.found)
                        matched_count++;
                    answer_queue.push_back(want);
                end
            end
            pending_count = answer_queue.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: clock, reset, command beats, response pacing and verdict
module testbench
    import vclit_pkg::*;
();

    localparam int NUM_SLOTS    = 1024;
    localparam int RANDOM_BEATS = 560;
    localparam int POOL_SIZE    = 8;
    localparam int HOLD_OFF     = 400;

    logic               clk;
    logic               rst_n;
    int                 beats_sent;
    int                 changes_sent;
    int                 finds_sent;
    int                 mismatches;
    int                 answers_pending;
    int                 finds_matched;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    vclit_in_if  cmd_if ();
    vclit_out_if rsp_if ();

    value_container_lowest_index_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if),
        .rsp  (rsp_if)
    );

    lowest_slot_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) answer_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_if),
        .rsp            (rsp_if),
        .mismatches     (mismatches),
        .answers_pending(answers_pending),
        .finds_matched  (finds_matched)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SLOT_INDEX_W-1:0] pick_slot();
        if ($urandom_range(0, 3) == 0)
            return SLOT_INDEX_W'($urandom);
        return SLOT_INDEX_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int fresh_pct);
        if ($urandom_range(0, 99) < fresh_pct)
            return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_beat(input logic act, input logic [SLOT_INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.action     <= act;
        cmd_if.slot_index <= idx;
        cmd_if.value      <= val;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        beats_sent++;
        if (act == ACT_CHANGE)
            changes_sent++;
        else
            finds_sent++;
    endtask

    initial
    begin
        cmd_if.valid      = 1'b0;
        cmd_if.action     = ACT_CHANGE;
        cmd_if.slot_index = '0;
        cmd_if.value      = '0;
        beats_sent        = 0;
        changes_sent      = 0;
        finds_sent        = 0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(ACT_FIND,   10'd0,    32'h0000_0000);
        send_beat(ACT_CHANGE, 10'd0,    32'h8000_0000);
        send_beat(ACT_CHANGE, 10'd1023, 32'h7FFF_FFFF);
        send_beat(ACT_FIND,   10'd0,    32'h7FFF_FFFF);
        send_beat(ACT_FIND,   10'd1023, 32'h8000_0000);
        send_beat(ACT_CHANGE, 10'd5,    32'hFFFF_FFFF);
        send_beat(ACT_CHANGE, 10'd3,    32'hFFFF_FFFF);
        send_beat(ACT_FIND,   10'd0,    32'hFFFF_FFFF);
        send_beat(ACT_CHANGE, 10'd3,    32'd42);
        send_beat(ACT_FIND,   10'd3,    32'hFFFF_FFFF);
        send_beat(ACT_FIND,   10'd0,    32'd42);
        send_beat(ACT_CHANGE, 10'd1023, 32'd42);
        send_beat(ACT_FIND,   10'd0,    32'd42);
        send_beat(ACT_FIND,   10'd0,    32'h7FFF_FFFF);
        send_beat(ACT_CHANGE, 10'h2AA,  32'h5555_5555);
        send_beat(ACT_CHANGE, 10'h155,  32'hAAAA_AAAA);
        send_beat(ACT_FIND,   10'h155,  32'h5555_5555);
        send_beat(ACT_FIND,   10'h2AA,  32'hAAAA_AAAA);
        send_beat(ACT_CHANGE, 10'd7,    32'h0000_0001);
        send_beat(ACT_FIND,   10'd7,    32'h8000_0001);
        send_beat(ACT_FIND,   10'd0,    32'h0000_0001);
        send_beat(ACT_CHANGE, 10'd0,    32'h0000_0001);
        send_beat(ACT_FIND,   10'd0,    32'h0000_0001);
        send_beat(ACT_FIND,   10'd0,    32'h8000_0000);

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int p = 4; p < POOL_SIZE; p++)
            value_pool[p] = $urandom;

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 99) < 55)
                send_beat(ACT_CHANGE, pick_slot(), pick_value(15));
            else
                send_beat(ACT_FIND, SLOT_INDEX_W'($urandom), pick_value(20));
        end
        cmd_if.valid <= 1'b0;

        @(posedge clk);
        wait (answers_pending == 0);
        repeat (NUM_SLOTS + 16) @(posedge clk);

        $display("summary: %0d change beats and %0d find beats accepted", changes_sent,
                 finds_sent);
        $display("summary: %0d finds matched a slot, %0d mismatches", finds_matched, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        int  run;
        bit  held;
        held         = 1'b0;
        rsp_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && beats_sent >= 60)
            begin
                // hold off long enough for the table to back up into cmd
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                run = pick_gap();
                if (run > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (run) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
